// ===== sv/frc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// frc_pkg
// Shared types and constants for the fraction reduce and compare block.
// ---------------------------------------------------------------------------
package frc_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int MAG_W      = DATA_WIDTH - 1;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int CNT_W      = $clog2(MAG_W + 1);

    localparam logic MODE_NORM = 1'b0;
    localparam logic MODE_CMP  = 1'b1;

    localparam logic signed [1:0] SIGN_ZERO = 2'sd0;
    localparam logic signed [1:0] SIGN_POS  = 2'sd1;
    localparam logic signed [1:0] SIGN_NEG  = -2'sd1;

    localparam logic [DATA_WIDTH-1:0] MIN_INT = {1'b1, {MAG_W{1'b0}}};

    typedef struct packed {
        logic                         mode;
        logic signed [DATA_WIDTH-1:0] first_num;
        logic signed [DATA_WIDTH-1:0] first_den;
        logic signed [DATA_WIDTH-1:0] second_num;
        logic        [MAG_W-1:0]      second_den;
    } item_t;

    typedef struct packed {
        logic signed [1:0]   result_sign;
        logic [MAG_W-1:0]    result_num;
        logic [MAG_W-1:0]    result_den;
        logic                is_less;
        logic                bad_input;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [MAG_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quotient;
        logic [MAG_W-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GCD_STEP,
        ST_GCD_WAIT,
        ST_NUM_DIV,
        ST_NUM_WAIT,
        ST_DEN_DIV,
        ST_DEN_WAIT,
        ST_MUL_FIRST,
        ST_MUL_SECOND,
        ST_CMP
    } state_t;

endpackage
`default_nettype wire

// ===== sv/frc_divider.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// frc_divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module frc_divider
(
    input  wire               clk,
    input  wire               rst_n,
    input  frc_pkg::div_req_t req,
    output frc_pkg::div_rsp_t rsp
);
    import frc_pkg::*;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MAG_W-1:0] rem_reg;
    logic [MAG_W-1:0] quo_reg;
    logic [MAG_W-1:0] dvs_reg;

    logic [MAG_W:0]   trial;
    logic [MAG_W:0]   diff;
    logic [MAG_W-1:0] rem_next;
    logic [MAG_W-1:0] quo_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[MAG_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = diff[MAG_W] ? trial[MAG_W-1:0] : diff[MAG_W-1:0];
        quo_next = {quo_reg[MAG_W-2:0], ~diff[MAG_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
`default_nettype wire

// ===== sv/frc_mul.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// frc_mul
// Signed multiplier with registered product for the cross products.
// ---------------------------------------------------------------------------
module frc_mul
(
    input  wire                                         clk,
    input  wire logic signed [frc_pkg::DATA_WIDTH-1:0]  a,
    input  wire logic signed [frc_pkg::DATA_WIDTH-1:0]  b,
    output logic signed [frc_pkg::PROD_W-1:0]           p
);
    import frc_pkg::*;

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule
`default_nettype wire

// ===== sv/fraction_reduce_compare.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fraction_reduce_compare
// Reduces a signed fraction to lowest terms or compares two fractions.
//
// An item is taken when start is high and busy is low. The result beat is
// shown on result for exactly one cycle with done high; the receiver cannot
// stall it. busy stays high from the accept until the cycle done rises, and
// a new item may be started in that same cycle.
// Normalize runs Euclid's algorithm on the shared serial divider, then
// divides numerator and denominator by the gcd on the same divider. An
// item with k remainder steps runs k + 2 divisions one after another;
// k is at most about 45 for 31-bit magnitudes. Zero denominator, zero
// numerator or the most negative value finish straight from the check
// state. Compare forms two cross products through one multiplier, then
// does one 64-bit compare.
// Reset clears the sequencer and the strobe; no clearing pass is needed.
// ---------------------------------------------------------------------------
module fraction_reduce_compare
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    output logic             busy,
    input  frc_pkg::item_t   item,
    output logic             done,
    output frc_pkg::result_t result
);
    import frc_pkg::*;

    state_t   state_reg;
    state_t   state_next;

    item_t    item_reg;
    logic [MAG_W-1:0] an_reg;
    logic [MAG_W-1:0] ad_reg;
    logic [MAG_W-1:0] a_reg;
    logic [MAG_W-1:0] b_reg;
    logic [MAG_W-1:0] num_reg;
    logic signed [PROD_W-1:0] p1_reg;
    result_t  result_reg;
    logic     done_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;
    logic signed [DATA_WIDTH-1:0] mul_a;
    logic signed [DATA_WIDTH-1:0] mul_b;
    logic signed [PROD_W-1:0]     mul_p;

    logic [DATA_WIDTH-1:0] num_abs;
    logic [DATA_WIDTH-1:0] den_abs;
    logic     check_bad;
    logic     num_zero;
    logic     emit;
    result_t  result_next;

    frc_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    frc_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign num_abs  = item_reg.first_num[DATA_WIDTH-1] ? -item_reg.first_num
                                                       : item_reg.first_num;
    assign den_abs  = item_reg.first_den[DATA_WIDTH-1] ? -item_reg.first_den
                                                       : item_reg.first_den;
    assign num_zero = (item_reg.first_num == '0);

    always_comb
    begin
        if (item_reg.mode == MODE_CMP)
        begin
            check_bad = item_reg.first_den[DATA_WIDTH-1]
                     || (item_reg.first_den == '0)
                     || (item_reg.second_den == '0);
        end
        else
        begin
            check_bad = (item_reg.first_den == '0)
                     || (item_reg.first_num == MIN_INT)
                     || (item_reg.first_den == MIN_INT);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = ST_CHECK;
            ST_CHECK:
                if (check_bad)
                    state_next = ST_IDLE;
                else if (item_reg.mode == MODE_CMP)
                    state_next = ST_MUL_FIRST;
                else if (num_zero)
                    state_next = ST_IDLE;
                else
                    state_next = ST_GCD_STEP;
            ST_GCD_STEP:
                state_next = (b_reg == '0) ? ST_NUM_DIV : ST_GCD_WAIT;
            ST_GCD_WAIT:
                if (div_rsp.done)
                    state_next = ST_GCD_STEP;
            ST_NUM_DIV:
                state_next = ST_NUM_WAIT;
            ST_NUM_WAIT:
                if (div_rsp.done)
                    state_next = ST_DEN_DIV;
            ST_DEN_DIV:
                state_next = ST_DEN_WAIT;
            ST_DEN_WAIT:
                if (div_rsp.done)
                    state_next = ST_IDLE;
            ST_MUL_FIRST:
                state_next = ST_MUL_SECOND;
            ST_MUL_SECOND:
                state_next = ST_CMP;
            ST_CMP:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        div_req     = '0;
        mul_a       = item_reg.second_num;
        mul_b       = item_reg.first_den;
        emit        = 1'b0;
        result_next = '0;
        case (state_reg)
            ST_CHECK:
            begin
                if (check_bad)
                begin
                    emit                  = 1'b1;
                    result_next.bad_input = 1'b1;
                end
                else if (item_reg.mode == MODE_NORM && num_zero)
                begin
                    emit                   = 1'b1;
                    result_next.result_den = MAG_W'(1);
                end
            end
            ST_GCD_STEP:
            begin
                div_req.start    = (b_reg != '0);
                div_req.dividend = a_reg;
                div_req.divisor  = b_reg;
            end
            ST_NUM_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = an_reg;
                div_req.divisor  = a_reg;
            end
            ST_DEN_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = ad_reg;
                div_req.divisor  = a_reg;
            end
            ST_DEN_WAIT:
            begin
                emit = div_rsp.done;
                result_next.result_sign =
                    (item_reg.first_num[DATA_WIDTH-1] ^ item_reg.first_den[DATA_WIDTH-1])
                    ? SIGN_NEG : SIGN_POS;
                result_next.result_num  = num_reg;
                result_next.result_den  = div_rsp.quotient;
            end
            ST_MUL_FIRST:
            begin
                mul_a = item_reg.first_num;
                mul_b = $signed({1'b0, item_reg.second_den});
            end
            ST_CMP:
            begin
                emit                = 1'b1;
                result_next.is_less = (p1_reg < mul_p);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
            item_reg <= item;
        if (state_reg == ST_CHECK)
        begin
            an_reg <= num_abs[MAG_W-1:0];
            ad_reg <= den_abs[MAG_W-1:0];
            a_reg  <= num_abs[MAG_W-1:0];
            b_reg  <= den_abs[MAG_W-1:0];
        end
        if (state_reg == ST_GCD_WAIT && div_rsp.done)
        begin
            a_reg <= b_reg;
            b_reg <= div_rsp.remainder;
        end
        if (state_reg == ST_NUM_WAIT && div_rsp.done)
            num_reg <= div_rsp.quotient;
        if (state_reg == ST_MUL_SECOND)
            p1_reg <= mul_p;
        if (emit)
            result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== sv/frc_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// frc_checker
// Port-level checks on the fraction block's command and result beats.
// ---------------------------------------------------------------------------
module frc_checker
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    input  wire              busy,
    input  wire              done,
    input  frc_pkg::result_t result
);
    import frc_pkg::*;

    property p_accept_busy;
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy;
    endproperty
    a_accept_busy: assert property (p_accept_busy)
        else $error("accepted beat did not raise busy");

    property p_fall_done;
        @(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done;
    endproperty
    a_fall_done: assert property (p_fall_done)
        else $error("busy dropped without a result beat");

    property p_done_idle;
        @(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy));
    endproperty
    a_done_idle: assert property (p_done_idle)
        else $error("result beat without a finished item");

    property p_bad_clean;
        @(posedge clk) disable iff (!rst_n)
        (done && result.bad_input) |->
            (result.result_sign == SIGN_ZERO && result.result_num == '0
             && result.result_den == '0 && !result.is_less);
    endproperty
    a_bad_clean: assert property (p_bad_clean)
        else $error("error beat carries nonzero fields");

    property p_norm_den;
        @(posedge clk) disable iff (!rst_n)
        (done && !result.bad_input && result.result_sign != SIGN_ZERO)
            |-> (result.result_den != '0 && result.result_num != '0);
    endproperty
    a_norm_den: assert property (p_norm_den)
        else $error("reduced fraction with zero term");

endmodule

bind fraction_reduce_compare frc_checker u_frc_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire
